### rtl/core/avr_pkg.sv
// shared types and constants for the axis vector rotation block
package avr_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 16;
    localparam int CRD_W        = 32;
    localparam int CS_W         = 32;
    localparam int PROD_W       = CS_W + CRD_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int FRAC_SHIFT   = 30;

    localparam logic signed [CS_W-1:0] GAIN_INIT = 32'sd652032874;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X    = 2'd0;
    localparam axis_t AXIS_Y    = 2'd1;
    localparam axis_t AXIS_Z    = 2'd2;
    localparam axis_t AXIS_NONE = 2'd3;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic signed [CS_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1
    };

    typedef struct packed {
        axis_t                    axis;
        logic                     flip;
        logic signed [CRD_W-1:0]  x;
        logic signed [CRD_W-1:0]  y;
        logic signed [CRD_W-1:0]  z;
    } side_t;

endpackage

### rtl/core/axis_vector_rotation.sv
// an item passes phase setup, 30 cordic stages, then sign fix, multiply and output stages
// throughput: one item per cycle unless a result is stalled, set by the fully unrolled
// sine/cosine and multiply pipeline; the whole pipeline then holds, and a one-item input
// skid keeps in_stall registered, so one more item is taken during an output stall
// reset: rst_n clears all valid bits and the skid; no data register is reset
module axis_vector_rotation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic signed [15:0]              angle,
    input  logic signed [31:0]              coord_x,
    input  logic signed [31:0]              coord_y,
    input  logic signed [31:0]              coord_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              rot_x,
    output logic signed [31:0]              rot_y,
    output logic signed [31:0]              rot_z
);
    import avr_pkg::*;

    localparam int NSTG = CORDIC_STEPS + 1;

    // input skid
    logic                       skid_vld_reg;
    logic                       skid_vld_next;
    logic [1:0]                 skid_axis_reg;
    logic signed [ANG_W-1:0]    skid_ang_reg;
    logic signed [CRD_W-1:0]    skid_x_reg;
    logic signed [CRD_W-1:0]    skid_y_reg;
    logic signed [CRD_W-1:0]    skid_z_reg;

    logic                       en;
    logic                       in_acc;

    // stage 0 source
    logic [1:0]                 src_axis;
    logic signed [ANG_W-1:0]    src_ang;
    logic signed [CRD_W-1:0]    src_x;
    logic signed [CRD_W-1:0]    src_y;
    logic signed [CRD_W-1:0]    src_z;
    logic                       src_flip;

    // cordic stages
    logic                       cv_reg [NSTG];
    logic signed [CS_W-1:0]     cx_reg [NSTG];
    logic signed [CS_W-1:0]     cy_reg [NSTG];
    logic signed [CS_W-1:0]     cz_reg [NSTG];
    side_t                      cs_reg [NSTG];

    // sign fix stage
    logic                       nv_reg;
    logic signed [CS_W-1:0]     cos_reg;
    logic signed [CS_W-1:0]     sin_reg;
    side_t                      ns_reg;

    // multiply stage
    logic                       mv_reg;
    logic signed [PROD_W-1:0]   cp_reg;
    logic signed [PROD_W-1:0]   sq_reg;
    logic signed [PROD_W-1:0]   cq_reg;
    logic signed [PROD_W-1:0]   sp_reg;
    side_t                      ms_reg;
    logic signed [CRD_W-1:0]    op_p;
    logic signed [CRD_W-1:0]    op_q;

    // output stage
    logic                       ov_reg;
    logic signed [CRD_W-1:0]    ox_reg;
    logic signed [CRD_W-1:0]    oy_reg;
    logic signed [CRD_W-1:0]    oz_reg;
    logic signed [CRD_W-1:0]    res_a;
    logic signed [CRD_W-1:0]    res_b;
    logic signed [CRD_W-1:0]    ox_next;
    logic signed [CRD_W-1:0]    oy_next;
    logic signed [CRD_W-1:0]    oz_next;

    function automatic logic signed [CRD_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0]            r;
        logic signed [SUM_W-FRAC_SHIFT-1:0] t;
        logic signed [SUM_W-FRAC_SHIFT-1:0] hi;
        logic signed [SUM_W-FRAC_SHIFT-1:0] lo;
        begin
            hi = {{(SUM_W-FRAC_SHIFT-CRD_W+1){1'b0}}, {(CRD_W-1){1'b1}}};
            lo = {{(SUM_W-FRAC_SHIFT-CRD_W+1){1'b1}}, {(CRD_W-1){1'b0}}};
            r  = v + (SUM_W'(1) <<< (FRAC_SHIFT - 1));
            t  = r[SUM_W-1:FRAC_SHIFT];
            if (t > hi)
            begin
                round_sat = {1'b0, {(CRD_W-1){1'b1}}};
            end
            else if (t < lo)
            begin
                round_sat = {1'b1, {(CRD_W-1){1'b0}}};
            end
            else
            begin
                round_sat = t[CRD_W-1:0];
            end
        end
    endfunction

    // whole pipeline moves unless a finished result is held back
    assign en       = !(ov_reg && out_stall);
    assign in_stall = skid_vld_reg;
    assign in_acc   = in_valid && !skid_vld_reg;

    always_comb
    begin
        skid_vld_next = skid_vld_reg ? !en : (in_acc && !en);
    end

    always_comb
    begin
        if (skid_vld_reg)
        begin
            src_axis = skid_axis_reg;
            src_ang  = skid_ang_reg;
            src_x    = skid_x_reg;
            src_y    = skid_y_reg;
            src_z    = skid_z_reg;
        end
        else
        begin
            src_axis = action;
            src_ang  = angle;
            src_x    = coord_x;
            src_y    = coord_y;
            src_z    = coord_z;
        end
        // outside [-90, +90) degrees the phase turns by half a turn
        src_flip = src_ang[ANG_W-1] ^ src_ang[ANG_W-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !en)
        begin
            skid_axis_reg <= action;
            skid_ang_reg  <= angle;
            skid_x_reg    <= coord_x;
            skid_y_reg    <= coord_y;
            skid_z_reg    <= coord_z;
        end
    end

    // stage 0: phase setup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= skid_vld_reg || in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]      <= GAIN_INIT;
            cy_reg[0]      <= '0;
            cz_reg[0]      <= {src_ang[ANG_W-1] ^ src_flip, src_ang[ANG_W-2:0],
                               {(CS_W-ANG_W){1'b0}}};
            cs_reg[0].axis <= src_axis;
            cs_reg[0].flip <= src_flip;
            cs_reg[0].x    <= src_x;
            cs_reg[0].y    <= src_y;
            cs_reg[0].z    <= src_z;
        end
    end

    // one cordic iteration per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CS_W-1:0] dx;
        logic signed [CS_W-1:0] dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[i][CS_W-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - ATAN_TBL[i];
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + ATAN_TBL[i];
                end
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    // sign fix, operand select and products, round and route
    always_comb
    begin
        case (ns_reg.axis)
            AXIS_X:
            begin
                op_p = ns_reg.y;
                op_q = ns_reg.z;
            end
            AXIS_Y:
            begin
                op_p = ns_reg.z;
                op_q = ns_reg.x;
            end
            default:
            begin
                op_p = ns_reg.x;
                op_q = ns_reg.y;
            end
        endcase
    end

    // a = c*p + s*q, b = c*q - s*p
    always_comb
    begin
        res_a   = round_sat(SUM_W'(cp_reg) + SUM_W'(sq_reg));
        res_b   = round_sat(SUM_W'(cq_reg) - SUM_W'(sp_reg));
        ox_next = ms_reg.x;
        oy_next = ms_reg.y;
        oz_next = ms_reg.z;
        case (ms_reg.axis)
            AXIS_X:
            begin
                oy_next = res_a;
                oz_next = res_b;
            end
            AXIS_Y:
            begin
                oz_next = res_a;
                ox_next = res_b;
            end
            AXIS_Z:
            begin
                ox_next = res_a;
                oy_next = res_b;
            end
            default:
            begin
                ox_next = ms_reg.x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 1'b0;
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            nv_reg <= cv_reg[CORDIC_STEPS];
            mv_reg <= nv_reg;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cs_reg[CORDIC_STEPS].flip)
            begin
                cos_reg <= -cx_reg[CORDIC_STEPS];
                sin_reg <= -cy_reg[CORDIC_STEPS];
            end
            else
            begin
                cos_reg <= cx_reg[CORDIC_STEPS];
                sin_reg <= cy_reg[CORDIC_STEPS];
            end
            ns_reg <= cs_reg[CORDIC_STEPS];

            cp_reg <= cos_reg * op_p;
            sq_reg <= sin_reg * op_q;
            cq_reg <= cos_reg * op_q;
            sp_reg <= sin_reg * op_p;
            ms_reg <= ns_reg;

            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
        end
    end

    assign out_valid = ov_reg;
    assign rot_x     = ox_reg;
    assign rot_y     = oy_reg;
    assign rot_z     = oz_reg;

endmodule
